@@ hdl/w96_pkg.sv @@
package w96_pkg;

  typedef enum logic [3:0] {
    OP_TO_U32 = 4'd0,
    OP_TO_S32 = 4'd1,
    OP_TESTBIT = 4'd2,
    OP_SETBIT = 4'd3,
    OP_CLRBIT = 4'd4,
    OP_SHR1 = 4'd5,
    OP_SHL1 = 4'd6,
    OP_SHR = 4'd7,
    OP_SHL = 4'd8,
    OP_ADD = 4'd9,
    OP_SUB = 4'd10,
    OP_MUL = 4'd11,
    OP_CMP = 4'd12,
    OP_DIV = 4'd13
  } op_t;

  localparam int unsigned VAL_W = 96;
  localparam int unsigned SCL_W = 32;
  localparam int unsigned TOP_BIT = 95;
  // quotient bits resolved per divider stage
  localparam int unsigned DIV_BITS_PER_STAGE = 4;
  localparam int unsigned DIV_STAGES = VAL_W / DIV_BITS_PER_STAGE;

  // one pipeline word: the request plus the result and side results of the non-divide operations
  typedef struct packed {
    logic [3:0] req_type;
    logic [31:0] scalar;
    logic [95:0] value;
    logic [95:0] res;
    logic flag;
    logic [31:0] ovf;
    logic [1:0] order;
    logic error;
  } item_t;

endpackage

@@ hdl/w96_if.sv @@
interface w96_in_if;
  logic valid;
  logic ready;
  logic [3:0] req_type;
  logic [31:0] value_high;
  logic [63:0] value_low;
  logic [31:0] scalar;
  modport source (output valid, req_type, value_high, value_low, scalar, input ready);
  modport sink (input valid, req_type, value_high, value_low, scalar, output ready);
endinterface

interface w96_out_if;
  logic valid;
  logic ready;
  logic [31:0] result_high;
  logic [63:0] result_low;
  logic flag;
  logic [31:0] overflow_word;
  logic signed [1:0] order;
  logic error;
  modport source (output valid, result_high, result_low, flag, overflow_word, order, error,
                  input ready);
  modport sink (input valid, result_high, result_low, flag, overflow_word, order, error,
                output ready);
endinterface

@@ hdl/wide_96bit_arith_unit.sv @@
// 96-bit by 32-bit arithmetic unit, fully pipelined
// input channel in: one word carries req_type, value_high, value_low, scalar
// result channel out: one word per input word, in order, carrying
//   result_high, result_low, flag, overflow_word, order and error
// throughput: one word per cycle while the receiver does not stall, every operation including divide
// depth: the restoring divider sets the depth of the pipe, four
//   quotient bits per stage, and every operation travels the same pipe
// stage 0 registers the input, stage 1 computes the non-divide results and
//   the three 64-bit partial products, stage 2 sums the product, then the
//   divider stages follow and a final stage selects the answer
// the multiplier is split into three 32x32 products in one stage
// stall: the whole pipe advances only when the last stage is empty or is
//   being taken; nothing is dropped or repeated, in.ready falls while stalled
// reset: rst_n (synchronous, active low) clears all valid bits; no other
//   state is held and no words are in flight afterwards
module wide_96bit_arith_unit (
  input logic clk,
  input logic rst_n,
  w96_in_if.sink in_ch,
  w96_out_if.source out_ch
);

  localparam int unsigned NS = w96_pkg::DIV_STAGES;
  localparam int unsigned BS = w96_pkg::DIV_BITS_PER_STAGE;

  logic adv;
  // pipe advances when the output register is free or being drained
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 0: input register
  logic s0_v_r;
  w96_pkg::item_t s0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (adv) begin
      s0_v_r <= in_ch.valid;
    end
    if (adv) begin
      s0_r.req_type <= in_ch.req_type;
      s0_r.scalar <= in_ch.scalar;
      s0_r.value <= {in_ch.value_high, in_ch.value_low};
      s0_r.res <= '0;
      s0_r.flag <= 1'b0;
      s0_r.ovf <= '0;
      s0_r.order <= '0;
      s0_r.error <= 1'b0;
    end
  end

  // stage 1: simple operations and partial products
  w96_pkg::item_t s1_nxt;
  logic [63:0] p0_nxt, p1_nxt, p2_nxt;
  logic [95:0] v;
  logic [31:0] s;
  logic [6:0] sh;
  logic big;
  logic [64:0] add_lo;
  logic [32:0] add_hi;
  logic [96:0] sub_w;
  logic [95:0] bmask;
  always_comb begin
    v = s0_r.value;
    s = s0_r.scalar;
    sh = s[6:0];
    big = (s > 32'(w96_pkg::TOP_BIT));
    bmask = 96'd1 << sh;
    add_lo = {1'b0, v[63:0]} + {33'd0, s};
    add_hi = {1'b0, v[95:64]} + {32'd0, add_lo[64]};
    sub_w = {1'b0, v} - {65'd0, s};
    p0_nxt = 64'(v[31:0]) * 64'(s);
    p1_nxt = 64'(v[63:32]) * 64'(s);
    p2_nxt = 64'(v[95:64]) * 64'(s);
    s1_nxt = s0_r;
    s1_nxt.res = v;
    unique case (s0_r.req_type)
      w96_pkg::OP_TO_U32: begin
        s1_nxt.flag = (v[95:32] == '0);
        s1_nxt.res = {64'd0, v[31:0]};
      end
      w96_pkg::OP_TO_S32: begin
        s1_nxt.flag = (v[95:31] == '0);
        s1_nxt.res = {64'd0, v[31:0]};
      end
      w96_pkg::OP_TESTBIT: begin
        s1_nxt.error = big;
        s1_nxt.flag = !big && ((v & bmask) != '0);
      end
      w96_pkg::OP_SETBIT: begin
        s1_nxt.error = big;
        if (!big) s1_nxt.res = v | bmask;
      end
      w96_pkg::OP_CLRBIT: begin
        s1_nxt.error = big;
        if (!big) s1_nxt.res = v & ~bmask;
      end
      w96_pkg::OP_SHR1: begin
        s1_nxt.flag = v[0];
        s1_nxt.res = v >> 1;
      end
      w96_pkg::OP_SHL1: begin
        s1_nxt.flag = v[95];
        s1_nxt.res = v << 1;
      end
      w96_pkg::OP_SHR: begin
        s1_nxt.error = big;
        if (!big) s1_nxt.res = v >> sh;
      end
      w96_pkg::OP_SHL: begin
        s1_nxt.error = big;
        if (!big) s1_nxt.res = v << sh;
      end
      w96_pkg::OP_ADD: begin
        s1_nxt.res = {add_hi[31:0], add_lo[63:0]};
        s1_nxt.flag = add_hi[32];
      end
      w96_pkg::OP_SUB: begin
        s1_nxt.res = sub_w[95:0];
        s1_nxt.flag = sub_w[96];
      end
      w96_pkg::OP_CMP: begin
        if (v[95:32] != '0 || v[31:0] > s) s1_nxt.order = 2'b01;
        else if (v[31:0] < s) s1_nxt.order = 2'b11;
        else s1_nxt.order = 2'b00;
      end
      w96_pkg::OP_DIV: begin
        s1_nxt.error = (s == '0);
      end
      default: begin
      end
    endcase
  end

  logic s1_v_r;
  w96_pkg::item_t s1_r;
  logic [63:0] p0_r, p1_r, p2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= s0_v_r;
    end
    if (adv) begin
      s1_r <= s1_nxt;
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
    end
  end

  // stage 2: sum partial products into the 128-bit product
  logic [127:0] prod;
  w96_pkg::item_t s2_nxt;
  always_comb begin
    prod = {64'd0, p0_r} + {32'd0, p1_r, 32'd0} + {p2_r, 64'd0};
    s2_nxt = s1_r;
    if (s1_r.req_type == w96_pkg::OP_MUL) begin
      s2_nxt.res = prod[95:0];
      s2_nxt.ovf = prod[127:96];
    end
  end

  // divider stages: remainder and quotient travel with the word
  logic dv_v_r [NS+1];
  w96_pkg::item_t dv_r [NS+1];
  logic [31:0] rem_r [NS+1];
  logic [95:0] quo_r [NS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= s1_v_r;
    end
    if (adv) begin
      dv_r[0] <= s2_nxt;
      rem_r[0] <= '0;
      quo_r[0] <= s2_nxt.value;
    end
  end

  for (genvar g = 0; g < NS; g++) begin : g_div
    logic [31:0] rem_nxt;
    logic [95:0] quo_nxt;
    logic [32:0] trial;
    logic [32:0] diff;
    always_comb begin
      rem_nxt = rem_r[g];
      quo_nxt = quo_r[g];
      trial = '0;
      diff = '0;
      // restoring steps: shift in one dividend bit, try to subtract
      for (int k = 0; k < BS; k++) begin
        trial = {rem_nxt, quo_nxt[95]};
        diff = trial - {1'b0, dv_r[g].scalar};
        quo_nxt = {quo_nxt[94:0], !diff[32]};
        rem_nxt = diff[32] ? trial[31:0] : diff[31:0];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[g+1] <= 1'b0;
      end else if (adv) begin
        dv_v_r[g+1] <= dv_v_r[g];
      end
      if (adv) begin
        dv_r[g+1] <= dv_r[g];
        rem_r[g+1] <= rem_nxt;
        quo_r[g+1] <= quo_nxt;
      end
    end
  end

  // output stage: pick divide quotient or the earlier result
  logic out_v_r;
  logic [95:0] out_res_r;
  logic out_flag_r;
  logic [31:0] out_ovf_r;
  logic [1:0] out_ord_r;
  logic out_err_r;
  logic use_quo;
  assign use_quo = (dv_r[NS].req_type == w96_pkg::OP_DIV) && !dv_r[NS].error;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= dv_v_r[NS];
    end
    if (adv) begin
      out_res_r <= use_quo ? quo_r[NS] : dv_r[NS].res;
      out_flag_r <= dv_r[NS].flag;
      out_ovf_r <= dv_r[NS].ovf;
      out_ord_r <= dv_r[NS].order;
      out_err_r <= dv_r[NS].error;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.result_high = out_res_r[95:64];
  assign out_ch.result_low = out_res_r[63:0];
  assign out_ch.flag = out_flag_r;
  assign out_ch.overflow_word = out_ovf_r;
  assign out_ch.order = out_ord_r;
  assign out_ch.error = out_err_r;

  // held result stays put while the receiver stalls
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready |=> out_v_r && $stable(out_res_r))
    else $error("result changed under stall");
  // order is never the unused code
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_ord_r != 2'b10)
    else $error("bad order code");
  // an erroring word carries no flag and no overflow word
  a_errflag: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_err_r |-> !out_flag_r && out_ovf_r == '0)
    else $error("error word with flag");
  // nothing enters while stalled
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(s0_v_r) && $stable(dv_v_r[NS]))
    else $error("pipe moved under stall");

endmodule

@@ sim/wide_96bit_arith_unit_tb.sv @@
module wide_96bit_arith_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [3:0]  op;
    logic [31:0] vh;
    logic [63:0] vl;
    logic [31:0] sc;
  } req_t;

  typedef struct {
    logic [31:0] rh;
    logic [63:0] rl;
    logic        flag;
    logic [31:0] ovf;
    logic [1:0]  ord;
    logic        err;
  } ans_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   failed = 1'b0;
  bit   stim_done = 1'b0;
  bit   hold_long = 1'b0;
  bit   in_taken = 1'b0;

  w96_in_if  in_ch ();
  w96_out_if out_ch ();

  wide_96bit_arith_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  req_t pending_words[$];
  ans_t expected_answers[$];

  always #1 clk = ~clk;

  // arithmetic model of one request
  function automatic ans_t compute_answer(req_t r);
    ans_t a;
    logic [95:0]  v;
    logic [127:0] prod;
    logic [96:0]  wide;
    v = {r.vh, r.vl};
    a.flag = 1'b0; a.ovf = '0; a.ord = 2'b00; a.err = 1'b0;
    case (r.op)
      w96_pkg::OP_TO_U32: begin
        a.flag = (v[95:32] == '0);
        v = {64'd0, v[31:0]};
      end
      w96_pkg::OP_TO_S32: begin
        a.flag = (v[95:31] == '0);
        v = {64'd0, v[31:0]};
      end
      w96_pkg::OP_TESTBIT, w96_pkg::OP_SETBIT, w96_pkg::OP_CLRBIT: begin
        if (r.sc > w96_pkg::TOP_BIT) a.err = 1'b1;
        else if (r.op == w96_pkg::OP_TESTBIT) a.flag = v[r.sc[6:0]];
        else if (r.op == w96_pkg::OP_SETBIT) v[r.sc[6:0]] = 1'b1;
        else v[r.sc[6:0]] = 1'b0;
      end
      w96_pkg::OP_SHR1: begin
        a.flag = v[0];
        v = v >> 1;
      end
      w96_pkg::OP_SHL1: begin
        a.flag = v[95];
        v = v << 1;
      end
      w96_pkg::OP_SHR, w96_pkg::OP_SHL: begin
        if (r.sc > w96_pkg::TOP_BIT) a.err = 1'b1;
        else if (r.op == w96_pkg::OP_SHR) v = v >> r.sc;
        else v = v << r.sc;
      end
      w96_pkg::OP_ADD: begin
        wide = {1'b0, v} + {65'd0, r.sc};
        a.flag = wide[96];
        v = wide[95:0];
      end
      w96_pkg::OP_SUB: begin
        a.flag = (v < {64'd0, r.sc});
        v = v - {64'd0, r.sc};
      end
      w96_pkg::OP_MUL: begin
        prod = {32'd0, v} * {96'd0, r.sc};
        v = prod[95:0];
        a.ovf = prod[127:96];
      end
      w96_pkg::OP_CMP: begin
        if (v > {64'd0, r.sc}) a.ord = 2'b01;
        else if (v < {64'd0, r.sc}) a.ord = 2'b11;
      end
      w96_pkg::OP_DIV: begin
        if (r.sc == '0) a.err = 1'b1;
        else v = v / {64'd0, r.sc};
      end
      default: ;
    endcase
    a.rh = v[95:64];
    a.rl = v[63:0];
    return a;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [31:0] pick_scalar(logic [3:0] op);
    int p;
    p = $urandom_range(0, 9);
    case (op)
      w96_pkg::OP_TESTBIT, w96_pkg::OP_SETBIT, w96_pkg::OP_CLRBIT, w96_pkg::OP_SHR,
      w96_pkg::OP_SHL:
        if (p < 8) return $urandom_range(0, 95);
        else if (p < 9) return $urandom_range(96, 200);
        else return $urandom();
      w96_pkg::OP_DIV:
        if (p == 0) return 32'd0;
        else if (p < 4) return $urandom_range(1, 16);
        else return $urandom();
      default:
        if (p < 2) return {32{1'b1}};
        else return $urandom();
    endcase
  endfunction

  // request value shapes: small, full, below 2^31, random
  function automatic req_t random_req();
    req_t r;
    int   shape;
    r.op = 4'($urandom_range(0, 15));
    shape = $urandom_range(0, 7);
    case (shape)
      0: begin r.vh = '0; r.vl = {32'd0, $urandom()}; end
      1: begin r.vh = '1; r.vl = '1; end
      2: begin r.vh = '0; r.vl = {32'd0, 1'b0, 31'($urandom())}; end
      default: begin r.vh = $urandom(); r.vl = rand64(); end
    endcase
    r.sc = pick_scalar(r.op);
    if (r.op == w96_pkg::OP_CMP && shape == 0 && $urandom_range(0, 2) == 0)
      r.sc = r.vl[31:0];
    return r;
  endfunction

  task automatic add_req(logic [3:0] op, logic [31:0] vh, logic [63:0] vl,
                         logic [31:0] sc);
    req_t r;
    r.op = op; r.vh = vh; r.vl = vl; r.sc = sc;
    pending_words.push_back(r);
  endtask

  // directed cases then random words
  initial begin
    add_req(w96_pkg::OP_TO_U32, 32'd0, 64'h0000_0000_FFFF_FFFF, 32'd0);
    add_req(w96_pkg::OP_TO_U32, 32'd0, 64'h0000_0001_0000_0000, 32'd0);
    add_req(w96_pkg::OP_TO_S32, 32'd0, 64'h0000_0000_7FFF_FFFF, 32'd0);
    add_req(w96_pkg::OP_TO_S32, 32'd0, 64'h0000_0000_8000_0000, 32'd0);
    add_req(w96_pkg::OP_TESTBIT, 32'h8000_0000, 64'd1, 32'd95);
    add_req(w96_pkg::OP_SETBIT, 32'd0, 64'd0, 32'd64);
    add_req(w96_pkg::OP_CLRBIT, '1, '1, 32'd63);
    add_req(w96_pkg::OP_TESTBIT, '1, '1, 32'd96);
    add_req(w96_pkg::OP_SHR1, '1, 64'd1, 32'd0);
    add_req(w96_pkg::OP_SHL1, 32'h8000_0000, '1, 32'd0);
    add_req(w96_pkg::OP_SHR, 32'hDEAD_BEEF, 64'h0123_4567_89AB_CDEF, 32'd0);
    add_req(w96_pkg::OP_SHR, 32'hDEAD_BEEF, 64'h0123_4567_89AB_CDEF, 32'd64);
    add_req(w96_pkg::OP_SHL, 32'hDEAD_BEEF, 64'h0123_4567_89AB_CDEF, 32'd95);
    add_req(w96_pkg::OP_SHL, 32'hDEAD_BEEF, 64'h0123_4567_89AB_CDEF, 32'd70);
    add_req(w96_pkg::OP_SHR, '1, '1, '1);
    add_req(w96_pkg::OP_ADD, '1, '1, 32'd1);
    add_req(w96_pkg::OP_SUB, 32'd0, 64'd0, 32'd1);
    add_req(w96_pkg::OP_MUL, '1, '1, '1);
    add_req(w96_pkg::OP_CMP, 32'd0, 64'd5, 32'd5);
    add_req(w96_pkg::OP_CMP, 32'd0, 64'd4, 32'd5);
    add_req(w96_pkg::OP_CMP, 32'd1, 64'd0, 32'd5);
    add_req(w96_pkg::OP_DIV, '1, '1, 32'd0);
    add_req(w96_pkg::OP_DIV, '1, '1, '1);
    add_req(w96_pkg::OP_DIV, '1, '1, 32'd1);
    add_req(4'd14, '1, '1, '1);
    add_req(4'd15, 32'd3, 64'd3, 32'd3);
    repeat (1800) pending_words.push_back(random_req());
  end

  // input handshake as seen at the rising edge
  always @(posedge clk) begin
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
  end

  // driver: offers pending words at the falling edge
  int unsigned drv_gap = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_taken) begin
        expected_answers.push_back(compute_answer(pending_words.pop_front()));
        drv_gap = gap_len();
      end
      if (pending_words.size() == 0) begin
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;
      end else if (drv_gap != 0 && !(in_ch.valid && !in_taken)) begin
        drv_gap--;
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid <= 1'b1;
        in_ch.req_type <= pending_words[0].op;
        in_ch.value_high <= pending_words[0].vh;
        in_ch.value_low <= pending_words[0].vl;
        in_ch.scalar <= pending_words[0].sc;
      end
    end
  end

  // long hold-off of the receiver early in the random part
  initial begin
    wait (rst_n);
    repeat (200) @(posedge clk);
    hold_long = 1'b1;
    repeat (120) @(posedge clk);
    hold_long = 1'b0;
  end

  // receiver ready with random stalls
  int unsigned rcv_gap = 0;
  always @(negedge clk) begin
    if (!rst_n || hold_long) begin
      out_ch.ready <= 1'b0;
    end else if (rcv_gap != 0) begin
      rcv_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      rcv_gap = gap_len();
    end
  end

  // monitor: checks each accepted result word
  always @(posedge clk) begin
    ans_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result word rh=%h rl=%h", $time,
                 out_ch.result_high, out_ch.result_low);
        failed = 1'b1;
      end else begin
        e = expected_answers.pop_front();
        if ({out_ch.result_high, out_ch.result_low, out_ch.flag, out_ch.overflow_word,
             out_ch.order, out_ch.error} !== {e.rh, e.rl, e.flag, e.ovf, e.ord, e.err}) begin
          $display("%0t: mismatch expected rh=%h rl=%h f=%b ovf=%h ord=%b err=%b",
                   $time, e.rh, e.rl, e.flag, e.ovf, e.ord, e.err);
          $display("%0t:          actual rh=%h rl=%h f=%b ovf=%h ord=%b err=%b",
                   $time, out_ch.result_high, out_ch.result_low, out_ch.flag,
                   out_ch.overflow_word, out_ch.order, out_ch.error);
          failed = 1'b1;
        end
      end
    end
  end

  // reset, drain and final verdict
  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = '0;
    in_ch.value_high = '0;
    in_ch.value_low = '0;
    in_ch.scalar = '0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    wait (stim_done);
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (!failed && expected_answers.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // overall time limit
  initial begin
    #400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/w96_pkg.sv
hdl/w96_if.sv
hdl/wide_96bit_arith_unit.sv
sim/wide_96bit_arith_unit_tb.sv
